>>> hw/rtl/lobm_pkg.sv
// shared types and constants for the limit order book matcher
// no dependencies
`default_nettype none
package lobm_pkg;
    localparam int BOOK_SLOTS = 32;
    localparam int SLOT_W = $clog2(BOOK_SLOTS);

    localparam logic [2:0] EV_FILL     = 3'd0;
    localparam logic [2:0] EV_RESTED   = 3'd1;
    localparam logic [2:0] EV_DONE     = 3'd2;
    localparam logic [2:0] EV_FULL     = 3'd3;
    localparam logic [2:0] EV_CANCELED = 3'd4;
    localparam logic [2:0] EV_NOTFOUND = 3'd5;

    // controller to datapath
    typedef struct packed {
        logic load;       // capture input beat
        logic scan_clr;   // start a scan
        logic scan_step;  // examine slot at scan index
        logic do_fill;    // apply fill against best slot
        logic do_rest;    // write remainder into free slot
        logic do_cancel;  // free the matched slot
        logic emit;       // load output register
        logic [2:0] ev;
        logic ev_last;
    } lobm_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic kind;
        logic qty_zero;
        logic scan_done;
        logic best_found;
        logic crosses;
        logic free_found;
        logic id_found;
    } lobm_sts_t;
endpackage
`default_nettype wire

>>> hw/rtl/limit_order_book_matcher_top.sv
// limit order book matcher: controller plus book datapath
// the book is scanned serially, one slot per cycle, then a decide state picks the
// result; each fill starts a new scan, and a stalled output holds the decide state;
// a new order is accepted only once the last result beat of the previous one is loaded
// rst_n asynchronous active low: clears slot valid bits, arrival count, control
`default_nettype none
module limit_order_book_matcher_top
    import lobm_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        kind,
    input  wire logic [30:0] order_id,
    input  wire logic        side,
    input  wire logic [19:0] limit_price,
    input  wire logic [15:0] amount,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [2:0]       event_res,
    output logic [15:0]      fill_amount,
    output logic [19:0]      fill_price,
    output logic [30:0]      counter_id,
    output logic             last
);
    lobm_cmd_t cmd;
    lobm_sts_t sts;

    lobm_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .out_valid(out_valid), .out_ready(out_ready), .sts(sts), .cmd(cmd)
    );

    lobm_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
        .in_kind(kind), .in_id(order_id), .in_side(side),
        .in_price(limit_price), .in_amount(amount),
        .o_ev(event_res), .o_amt(fill_amount), .o_price(fill_price),
        .o_id(counter_id), .o_last(last)
    );

`ifndef SYNTHESIS
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(event_res)
            && $stable(fill_amount) && $stable(fill_price)
            && $stable(counter_id) && $stable(last)))
        else $error("result beat changed while waiting");
    a_last_not_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && last) |-> (event_res != EV_FILL))
        else $error("fill marked as last beat");
    a_fill_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && event_res == EV_FILL) |-> (fill_amount != 16'd0))
        else $error("empty fill");
`endif
endmodule
`default_nettype wire

>>> hw/rtl/lobm_datapath.sv
// book storage, serial best/free/id scan and output register
// depends on lobm_pkg
`default_nettype none
module lobm_datapath
    import lobm_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire lobm_cmd_t   cmd,
    output lobm_sts_t        sts,
    input  wire logic        in_kind,
    input  wire logic [30:0] in_id,
    input  wire logic        in_side,
    input  wire logic [19:0] in_price,
    input  wire logic [15:0] in_amount,
    output logic [2:0]       o_ev,
    output logic [15:0]      o_amt,
    output logic [19:0]      o_price,
    output logic [30:0]      o_id,
    output logic             o_last
);
    logic [BOOK_SLOTS-1:0] valid_reg;
    logic                  side_mem [BOOK_SLOTS];
    logic [19:0]           price_mem [BOOK_SLOTS];
    logic [15:0]           rem_mem [BOOK_SLOTS];
    logic [30:0]           owner_mem [BOOK_SLOTS];
    logic [31:0]           arr_mem [BOOK_SLOTS];
    logic [31:0]           arrival_reg;

    logic        kind_reg, side_reg;
    logic [30:0] id_reg;
    logic [19:0] price_reg;
    logic [15:0] qty_reg;

    logic [SLOT_W:0]   idx_reg;
    logic              best_ok_reg, free_ok_reg, id_ok_reg;
    logic [SLOT_W-1:0] best_reg, free_reg, hit_reg;
    logic [19:0]       bprice_reg;
    logic [31:0]       bage_reg;
    logic [15:0]       brem_reg;
    logic [30:0]       bowner_reg;

    logic [SLOT_W-1:0] ix;
    logic [31:0]       age;
    logic              cand, better;
    logic [15:0]       m;

    assign ix  = idx_reg[SLOT_W-1:0];
    assign age = arrival_reg - arr_mem[ix];
    assign cand = valid_reg[ix] && (side_mem[ix] != side_reg);

    always_comb
    begin
        priority if (price_mem[ix] == bprice_reg)
            better = age > bage_reg;
        else if (!side_reg)
            better = price_mem[ix] < bprice_reg;
        else
            better = price_mem[ix] > bprice_reg;
    end

    assign m = (qty_reg < brem_reg) ? qty_reg : brem_reg;

    assign sts.kind       = kind_reg;
    assign sts.qty_zero   = (qty_reg == 16'd0);
    assign sts.scan_done  = (idx_reg == (SLOT_W+1)'(BOOK_SLOTS));
    assign sts.best_found = best_ok_reg;
    assign sts.crosses    = side_reg ? (price_reg <= bprice_reg) : (price_reg >= bprice_reg);
    assign sts.free_found = free_ok_reg;
    assign sts.id_found   = id_ok_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= '0;
            arrival_reg <= '0;
            idx_reg     <= '0;
            best_ok_reg <= 1'b0;
            free_ok_reg <= 1'b0;
            id_ok_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.scan_clr)
            begin
                idx_reg     <= '0;
                best_ok_reg <= 1'b0;
                free_ok_reg <= 1'b0;
                id_ok_reg   <= 1'b0;
            end
            else if (cmd.scan_step)
            begin
                idx_reg <= idx_reg + 1'b1;
                if (cand && (!best_ok_reg || better))
                    best_ok_reg <= 1'b1;
                if (!valid_reg[ix] && !free_ok_reg)
                    free_ok_reg <= 1'b1;
                if (valid_reg[ix] && owner_mem[ix] == id_reg && !id_ok_reg)
                    id_ok_reg <= 1'b1;
            end
            if (cmd.do_fill && (brem_reg == m))
                valid_reg[best_reg] <= 1'b0;
            if (cmd.do_cancel)
                valid_reg[hit_reg] <= 1'b0;
            if (cmd.do_rest)
            begin
                valid_reg[free_reg] <= 1'b1;
                arrival_reg         <= arrival_reg + 32'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg  <= in_kind;
            id_reg    <= in_id;
            side_reg  <= in_side;
            price_reg <= in_price;
            qty_reg   <= in_amount;
        end
        if (cmd.scan_step)
        begin
            if (cand && (!best_ok_reg || better))
            begin
                best_reg   <= ix;
                bprice_reg <= price_mem[ix];
                bage_reg   <= age;
                brem_reg   <= rem_mem[ix];
                bowner_reg <= owner_mem[ix];
            end
            if (!valid_reg[ix] && !free_ok_reg)
                free_reg <= ix;
            if (valid_reg[ix] && owner_mem[ix] == id_reg && !id_ok_reg)
                hit_reg <= ix;
        end
        if (cmd.do_fill)
        begin
            qty_reg           <= qty_reg - m;
            rem_mem[best_reg] <= brem_reg - m;
        end
        if (cmd.do_rest)
        begin
            side_mem[free_reg]  <= side_reg;
            price_mem[free_reg] <= price_reg;
            rem_mem[free_reg]   <= qty_reg;
            owner_mem[free_reg] <= id_reg;
            arr_mem[free_reg]   <= arrival_reg;
        end
        if (cmd.emit)
        begin
            o_ev   <= cmd.ev;
            o_last <= cmd.ev_last;
            if (cmd.ev == EV_FILL)
            begin
                o_amt   <= m;
                o_price <= bprice_reg;
                o_id    <= bowner_reg;
            end
            else
            begin
                o_amt   <= '0;
                o_price <= '0;
                o_id    <= id_reg;
            end
        end
    end
endmodule
`default_nettype wire

>>> hw/rtl/lobm_ctrl.sv
// sequencing state machine for submit and cancel handling
// depends on lobm_pkg
`default_nettype none
module lobm_ctrl
    import lobm_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  wire logic out_ready,
    input  wire lobm_sts_t sts,
    output lobm_cmd_t cmd
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_DEC  = 3'd2;
    localparam logic [2:0] S_OUT  = 3'd3;

    logic [2:0] state_reg, state_next;
    logic       ov_reg, ov_next;
    logic       fin_reg, fin_next;  // last beat loaded, return to idle

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = ov_reg;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        ov_next    = ov_reg;
        fin_next   = fin_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load     = 1'b1;
                    cmd.scan_clr = 1'b1;
                    state_next   = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (sts.scan_done)
                    state_next = S_DEC;
                else
                    cmd.scan_step = 1'b1;
            end
            S_DEC:
            begin
                // output register must be free before the next beat
                if (!ov_reg || out_ready)
                begin
                    cmd.emit    = 1'b1;
                    ov_next     = 1'b1;
                    cmd.ev_last = 1'b1;
                    fin_next    = 1'b1;
                    state_next  = S_OUT;
                    if (sts.kind)
                    begin
                        cmd.ev        = sts.id_found ? EV_CANCELED : EV_NOTFOUND;
                        cmd.do_cancel = sts.id_found;
                    end
                    else if (sts.qty_zero)
                        cmd.ev = EV_DONE;
                    else if (sts.best_found && sts.crosses)
                    begin
                        cmd.ev       = EV_FILL;
                        cmd.ev_last  = 1'b0;
                        cmd.do_fill  = 1'b1;
                        cmd.scan_clr = 1'b1;
                        fin_next     = 1'b0;
                    end
                    else if (sts.free_found)
                    begin
                        cmd.ev      = EV_RESTED;
                        cmd.do_rest = 1'b1;
                    end
                    else
                        cmd.ev = EV_FULL;
                end
                else
                    ov_next = ov_reg;
            end
            S_OUT:
            begin
                // the beat waits in the output register while the next scan runs
                if (out_ready)
                    ov_next = 1'b0;
                state_next = fin_reg ? S_IDLE : S_SCAN;
            end
            default:
                state_next = S_IDLE;
        endcase
        if (state_reg != S_OUT && state_reg != S_DEC && ov_reg && out_ready)
            ov_next = 1'b0;
        if (state_reg == S_DEC && ov_reg && out_ready && !cmd.emit)
            ov_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ov_reg    <= 1'b0;
            fin_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
            fin_reg   <= fin_next;
        end
    end
endmodule
`default_nettype wire

>>> test/limit_order_book_matcher_top_tb.sv
// testbench for limit_order_book_matcher_top: predicts fills, rests and cancels
// depends on lobm_pkg and the matcher rtl
`default_nettype none
module limit_order_book_matcher_top_tb;
    import lobm_pkg::*;

    typedef struct packed {
        logic [2:0]  ev;
        logic [15:0] qty;
        logic [19:0] px;
        logic [30:0] id;
        logic        fin;
    } book_event_t;

    localparam int EV_DEPTH  = 4096;
    localparam int RECENT_N  = 48;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic        kind;
    logic [30:0] order_id;
    logic        side;
    logic [19:0] limit_price;
    logic [15:0] amount;
    logic        out_valid;
    logic        out_ready;
    logic [2:0]  event_res;
    logic [15:0] fill_amount;
    logic [19:0] fill_price;
    logic [30:0] counter_id;
    logic        last;

    limit_order_book_matcher_top dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .kind(kind), .order_id(order_id), .side(side),
        .limit_price(limit_price), .amount(amount),
        .out_valid(out_valid), .out_ready(out_ready),
        .event_res(event_res), .fill_amount(fill_amount), .fill_price(fill_price),
        .counter_id(counter_id), .last(last)
    );

    // shadow book
    logic        bk_valid [BOOK_SLOTS];
    logic        bk_side  [BOOK_SLOTS];
    logic [19:0] bk_price [BOOK_SLOTS];
    logic [15:0] bk_left  [BOOK_SLOTS];
    logic [30:0] bk_owner [BOOK_SLOTS];
    logic [31:0] bk_stamp [BOOK_SLOTS];
    logic [31:0] stamp_next;

    // expected beats, ring with free-running indexes
    book_event_t ev_fifo [EV_DEPTH];
    int          ev_wr;
    int          ev_rd;
    int          errors;
    bit          hold_off;
    int          idle_max;
    logic [30:0] recent_ids [RECENT_N];
    int          recent_cnt;
    int          recent_wr;

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    function automatic void queue_event(input book_event_t e);
        begin
            ev_fifo[ev_wr % EV_DEPTH] = e;
            ev_wr++;
        end
    endfunction

    function automatic book_event_t next_event();
        book_event_t e;
        begin
            e = ev_fifo[ev_rd % EV_DEPTH];
            ev_rd++;
            return e;
        end
    endfunction

    task automatic report(input string what, input book_event_t got, input book_event_t want);
        begin
            $display("mismatch %s: got ev=%0d q=%0d p=%0d id=%0d l=%0d %s",
                     what, got.ev, got.qty, got.px, got.id, got.fin,
                     $sformatf("want ev=%0d q=%0d p=%0d id=%0d l=%0d",
                               want.ev, want.qty, want.px, want.id, want.fin));
            errors++;
        end
    endtask

    function automatic int best_opposite(input logic s);
        int          b;
        logic [31:0] b_age;
        logic [31:0] age;
        logic        better;
        begin
            b = -1;
            b_age = 0;
            for (int i = 0; i < BOOK_SLOTS; i++)
            begin
                if (bk_valid[i] && bk_side[i] != s)
                begin
                    age = stamp_next - bk_stamp[i];
                    if (b < 0)
                        better = 1'b1;
                    else if (bk_price[i] == bk_price[b])
                        better = age > b_age;
                    else if (s == 1'b0)
                        better = bk_price[i] < bk_price[b];
                    else
                        better = bk_price[i] > bk_price[b];
                    if (better)
                    begin
                        b = i;
                        b_age = age;
                    end
                end
            end
            return b;
        end
    endfunction

    task automatic predict_book(input logic k, input logic [30:0] id, input logic s,
                                input logic [19:0] px, input logic [15:0] q);
        int          b;
        logic [15:0] m;
        logic [15:0] left;
        bit          done;
        begin
            left = q;
            done = 0;
            if (k)
            begin
                for (int i = 0; i < BOOK_SLOTS && !done; i++)
                    if (bk_valid[i] && bk_owner[i] == id)
                    begin
                        bk_valid[i] = 1'b0;
                        done = 1;
                    end
                queue_event({done ? EV_CANCELED : EV_NOTFOUND, 16'd0, 20'd0, id, 1'b1});
            end
            else
            begin
                while (left != 0 && !done)
                begin
                    b = best_opposite(s);
                    if (b < 0 || (s == 1'b0 ? px < bk_price[b] : px > bk_price[b]))
                        done = 1;
                    else
                    begin
                        m = left < bk_left[b] ? left : bk_left[b];
                        left -= m;
                        bk_left[b] -= m;
                        queue_event({EV_FILL, m, bk_price[b], bk_owner[b], 1'b0});
                        if (bk_left[b] == 0)
                            bk_valid[b] = 1'b0;
                    end
                end
                if (left == 0)
                    queue_event({EV_DONE, 16'd0, 20'd0, id, 1'b1});
                else
                begin
                    done = 0;
                    for (int i = 0; i < BOOK_SLOTS && !done; i++)
                        if (!bk_valid[i])
                        begin
                            bk_valid[i] = 1'b1;
                            bk_side[i] = s;
                            bk_price[i] = px;
                            bk_left[i] = left;
                            bk_owner[i] = id;
                            bk_stamp[i] = stamp_next;
                            stamp_next++;
                            done = 1;
                        end
                    queue_event({done ? EV_RESTED : EV_FULL, 16'd0, 20'd0, id, 1'b1});
                end
            end
        end
    endtask

    // one beat on the input channel, prediction at acceptance
    // valid stays high after acceptance; the next call or the caller drops it
    task automatic send_order(input logic k, input logic [30:0] id, input logic s,
                              input logic [19:0] px, input logic [15:0] q);
        int gap;
        begin
            gap = $urandom_range(0, idle_max);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            in_valid <= 1'b1;
            kind <= k;
            order_id <= id;
            side <= s;
            limit_price <= px;
            amount <= q;
            @(posedge clk);
            while (!in_ready)
                @(posedge clk);
            predict_book(k, id, s, px, q);
            recent_ids[recent_wr] = id;
            recent_wr = (recent_wr + 1) % RECENT_N;
            if (recent_cnt < RECENT_N)
                recent_cnt++;
        end
    endtask

    always @(posedge clk)
    begin
        if (out_valid && out_ready)
        begin
            book_event_t got;
            book_event_t want;
            got = {event_res, fill_amount, fill_price, counter_id, last};
            if (ev_wr == ev_rd)
            begin
                want = '0;
                report("unexpected beat", got, want);
            end
            else
            begin
                want = next_event();
                if (got.ev !== want.ev) report("event", got, want);
                else if (got.qty !== want.qty) report("amount", got, want);
                else if (got.px !== want.px) report("price", got, want);
                else if (got.id !== want.id) report("id", got, want);
                else if (got.fin !== want.fin) report("last", got, want);
            end
        end
    end

    // receiver stalls
    initial
    begin
        int gap;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off)
                out_ready <= 1'b0;
            else
            begin
                gap = idle_max == 0 ? 0 : $urandom_range(0, idle_max);
                if (gap != 0)
                begin
                    out_ready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
                out_ready <= 1'b1;
            end
        end
    end

    task automatic test_directed;
        begin
            idle_max = 0;
            send_order(1'b1, 31'd5, 1'b0, 20'd0, 16'd1);              // cancel on empty book
            send_order(1'b0, 31'd1, 1'b0, 20'd100, 16'd10);
            send_order(1'b0, 31'd2, 1'b0, 20'd100, 16'd5);
            send_order(1'b0, 31'd3, 1'b0, 20'd101, 16'd7);
            send_order(1'b1, 31'd3, 1'b1, 20'd0, 16'd1);
            send_order(1'b0, 31'd4, 1'b1, 20'd90, 16'd12);             // time priority at 100
            send_order(1'b0, 31'd5, 1'b1, 20'd100, 16'd20);            // partial then rest
            send_order(1'b0, 31'd6, 1'b0, 20'hFFFFF, 16'hFFFF);        // sweep, rest the remainder
            send_order(1'b0, 31'h7FFFFFFF, 1'b1, 20'd0, 16'hFFFF);     // full fill of the resting bid
            send_order(1'b0, 31'd7, 1'b1, 20'hFFFFF, 16'd3);
            send_order(1'b0, 31'd7, 1'b1, 20'hFFFFF, 16'd4);           // duplicate id
            send_order(1'b1, 31'd7, 1'b0, 20'd0, 16'd0);
            send_order(1'b1, 31'd7, 1'b0, 20'd0, 16'd0);
            send_order(1'b1, 31'd7, 1'b0, 20'd0, 16'd0);
            send_order(1'b0, 31'd8, 1'b0, 20'd1, 16'd0);               // zero amount
            for (int i = 0; i < BOOK_SLOTS + 2; i++)                   // fill book, then full
                send_order(1'b0, 31'(100 + i), 1'b1, 20'(5000 + i[1:0]), 16'd1);
            // one buy sweeping every resting ask: max result count
            send_order(1'b0, 31'd9, 1'b0, 20'hFFFFF, 16'hFFFF);
        end
    endtask

    task automatic test_random;
        logic [30:0] id;
        int          r;
        begin
            for (int n = 0; n < 400; n++)
            begin
                idle_max = (n / 60) % 2 == 0 ? 13 : 0;
                r = $urandom_range(0, 99);
                id = recent_cnt != 0 && $urandom_range(0, 3) == 0 ?
                     recent_ids[$urandom_range(0, recent_cnt - 1)] : 31'($urandom);
                if (r < 20)
                    send_order(1'b1, id, 1'($urandom), 20'($urandom), 16'($urandom));
                else if (r < 25)
                    send_order(1'b0, id, 1'($urandom), 20'($urandom),
                               $urandom_range(0, 3) == 0 ? 16'hFFFF : 16'($urandom));
                else
                    // narrow price band so books cross often
                    send_order(1'b0, id, 1'($urandom), 20'(1000 + $urandom_range(0, 15)),
                               16'($urandom_range(1, 40)));
            end
        end
    endtask

    task automatic test_backpressure;
        begin
            idle_max = 0;
            hold_off = 1'b1;
            fork
                begin
                    repeat (2000) @(posedge clk);
                    hold_off = 1'b0;
                end
                begin
                    for (int i = 0; i < 30; i++)
                        send_order(1'b0, 31'(500 + i), 1'($urandom),
                                   20'(1000 + $urandom_range(0, 3)),
                                   16'($urandom_range(1, 20)));
                    in_valid <= 1'b0;
                end
            join
            @(posedge clk);
        end
    endtask

    initial
    begin
        int waited;
        rst_n = 1'b0;
        in_valid = 1'b0;
        kind = 1'b0;
        order_id = '0;
        side = 1'b0;
        limit_price = '0;
        amount = '0;
        errors = 0;
        ev_wr = 0;
        ev_rd = 0;
        recent_cnt = 0;
        recent_wr = 0;
        hold_off = 1'b0;
        idle_max = 0;
        stamp_next = 0;
        for (int i = 0; i < BOOK_SLOTS; i++)
            bk_valid[i] = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_backpressure();
        test_random();
        in_valid <= 1'b0;
        waited = 0;
        while (ev_wr != ev_rd && waited < 200000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (200) @(posedge clk);
        if (errors == 0 && ev_wr == ev_rd)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        #50000000;
        $display("Verification failed");
        $finish;
    end
endmodule
`default_nettype wire

>>> sim.f
hw/rtl/lobm_pkg.sv
hw/rtl/lobm_datapath.sv
hw/rtl/lobm_ctrl.sv
hw/rtl/limit_order_book_matcher_top.sv
test/limit_order_book_matcher_top_tb.sv
